[rtl/round_robin_tile_register_allocator_core_defines.svh]
// assertion macros for the tile register allocator
`ifndef ROUND_ROBIN_TILE_REGISTER_ALLOCATOR_CORE_DEFINES_SVH
`define ROUND_ROBIN_TILE_REGISTER_ALLOCATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RRTRA_ASSERT(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("rrtra assertion failed");
`define RRTRA_ASSERT_NR(label, clk_s, prop) \
    label: assert property (@(posedge clk_s) prop) \
        else $error("rrtra assertion failed");
`else
`define RRTRA_ASSERT(label, clk_s, rst_s, prop)
`define RRTRA_ASSERT_NR(label, clk_s, prop)
`endif
`endif

[rtl/rrtra_pkg.sv]
`timescale 1ns / 1ps
package rrtra_pkg;

    localparam int       DIV_W    = 11;
    localparam logic [3:0] DIV_LAST = 4'd10;
    localparam logic [7:0] TE_RESET = 8'd24;
    localparam int       NEED_W   = 2 * DIV_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_DIV_H,
        ST_DIV_V,
        ST_NEED,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_WALK,
        ST_TAKE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       assigned;
        logic [3:0] preg_index;
        logic [2:0] tile_row;
        logic [2:0] tile_col;
        logic       evicted_valid;
        logic [3:0] evicted_vreg;
        logic       incomplete;
        logic       last;
    } result_t;

endpackage

[rtl/round_robin_tile_register_allocator_core.sv]
`timescale 1ns / 1ps
`include "round_robin_tile_register_allocator_core_defines.svh"
// Round-robin tile register allocator. Each request beat places one virtual register into
// physical register slots and returns one result beat per slot taken (or a single empty beat),
// the final one flagged by last. The block handles one request at a time and holds in_stall
// high from acceptance until its last result has entered the output register. The time from
// one accepted request to the next grows with the listed slots released, the slots visited in
// the walk, the slots taken and, for each evicted register, the entries of its list; stalls on
// the result side add to it. The shared bit-serial divider forms both tile counts at one
// quotient bit per cycle. Special-case requests skip the divider and give one empty beat.
// tile_edge must be written only while no request is in flight; the block does not enforce it.
module round_robin_tile_register_allocator_core #(
    parameter int NUM_SLOTS   = 16,
    parameter int NUM_VIRTUAL = 16,
    parameter int MAX_PLACE   = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  vreg_id,
    input  logic [9:0]  rows,
    input  logic [9:0]  cols,
    input  logic        is_vector,
    input  logic        orientation,
    input  logic [15:0] protected_mask,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        assigned,
    output logic [3:0]  preg_index,
    output logic [2:0]  tile_row,
    output logic [2:0]  tile_col,
    output logic        evicted_valid,
    output logic [3:0]  evicted_vreg,
    output logic        incomplete,
    output logic        last
);
    import rrtra_pkg::*;

    localparam int SW  = $clog2(NUM_SLOTS);
    localparam int VW  = $clog2(NUM_VIRTUAL);
    localparam int KW  = (MAX_PLACE > 1) ? $clog2(MAX_PLACE) : 1;
    localparam int CW  = $clog2(MAX_PLACE + 1);
    localparam int VCW = $clog2(NUM_SLOTS + 1);
    localparam int MEM_DEPTH = 1 << (VW + KW);

    state_t            state_reg, state_next;
    logic [7:0]        te_reg, te_next;
    logic [VW-1:0]     v_reg, v_next;
    logic [15:0]       pmask_reg, pmask_next;
    logic [9:0]        rows_reg, rows_next;
    logic              inc_reg, inc_next;
    logic [7:0]        div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]  div_q_reg, div_q_next;
    logic [3:0]        div_cnt_reg, div_cnt_next;
    logic [DIV_W-1:0]  htiles_reg, htiles_next;
    logic [DIV_W-1:0]  vtiles_reg, vtiles_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [NUM_SLOTS-1:0]   own_valid_reg, own_valid_next;
    logic [VW-1:0]     own_id_reg [NUM_SLOTS];
    logic [VW-1:0]     own_id_next [NUM_SLOTS];
    logic [CW-1:0]     cnt_reg [NUM_VIRTUAL];
    logic [CW-1:0]     cnt_next [NUM_VIRTUAL];
    logic [NUM_VIRTUAL-1:0] resident_reg, resident_next;
    logic [SW-1:0]     ptr_reg, ptr_next;
    logic [VCW-1:0]    visited_reg, visited_next;
    logic [CW-1:0]     taken_reg, taken_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [VW-1:0]     fv_reg, fv_next;
    logic              evict_mode_reg, evict_mode_next;
    logic [CW-1:0]     k_reg, k_next;
    logic              ev_reg, ev_next;
    logic [VW-1:0]     evv_reg, evv_next;
    logic              pend_valid_reg, pend_valid_next;
    result_t           pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic [SW-1:0]     pl_rd_reg;
    logic [SW-1:0]     pl_mem [MEM_DEPTH];

    logic              in_fire;
    logic              req_empty;
    logic              req_inc;
    logic [7:0]        te_eff;
    logic [8:0]        div_shift;
    logic [9:0]        div_diff;
    logic              div_ge;
    logic [7:0]        div_rem_step;
    logic [DIV_W-1:0]  div_q_step;
    logic              div_done;
    logic [SW-1:0]     owner_addr;
    logic              sel_valid;
    logic [VW-1:0]     sel_id;
    logic [7:0]        sel_id8;
    logic              sel_prot;
    logic [CW-1:0]     fv_cnt;
    logic              free_done;
    logic              walk_done;
    logic [SW-1:0]     ptr_inc;
    logic              out_free;
    logic              take_go;
    logic              out_push;
    result_t           out_data;
    result_t           empty_res;
    logic              mem_we;
    logic [VW+KW-1:0]  mem_waddr;
    logic [VW+KW-1:0]  mem_raddr;

    assign in_fire   = in_valid && (state_reg == ST_IDLE);
    assign req_empty = (is_vector && orientation) || ({28'd0, vreg_id} >= NUM_VIRTUAL)
                       || (rows == 10'd0) || (cols == 10'd0);
    assign req_inc   = !(is_vector && orientation) && ({28'd0, vreg_id} >= NUM_VIRTUAL);
    assign te_eff    = (te_reg == 8'd0) ? 8'd1 : te_reg;

    // shared restoring divider step
    assign div_shift    = {div_rem_reg, div_q_reg[DIV_W-1]};
    assign div_diff     = {1'b0, div_shift} - {2'b00, te_eff};
    assign div_ge       = !div_diff[9];
    assign div_rem_step = div_ge ? div_diff[7:0] : div_shift[7:0];
    assign div_q_step   = {div_q_reg[DIV_W-2:0], div_ge};
    assign div_done     = (div_cnt_reg == DIV_LAST);

    assign owner_addr = (state_reg == ST_FREE_CHK) ? pl_rd_reg : ptr_reg;
    assign sel_valid  = own_valid_reg[owner_addr];
    assign sel_id     = own_id_reg[owner_addr];
    assign sel_id8    = 8'(sel_id);
    assign sel_prot   = sel_valid && (sel_id8 < 8'd16) && pmask_reg[sel_id8[3:0]];

    assign fv_cnt    = cnt_reg[fv_reg];
    assign free_done = (k_reg == fv_cnt);
    assign walk_done = ({1'b0, visited_reg} >= (VCW + 1)'(NUM_SLOTS))
                       || !((NEED_W'(taken_reg) < need_reg)
                            && (taken_reg < CW'(MAX_PLACE)));
    assign ptr_inc   = (ptr_reg == SW'(NUM_SLOTS - 1)) ? '0 : ptr_reg + SW'(1);
    assign out_free  = !out_valid_reg || !out_stall;
    assign take_go   = !pend_valid_reg || out_free;

    assign mem_waddr = {v_reg, taken_reg[KW-1:0]};
    assign mem_raddr = {fv_reg, k_reg[KW-1:0]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = req_empty ? ST_EMPTY : ST_DIV_H;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_H:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_V;
                end
            end
            ST_DIV_V:
            begin
                if (div_done)
                begin
                    state_next = ST_NEED;
                end
            end
            ST_NEED:     state_next = ST_FREE_RD;
            ST_FREE_RD:
            begin
                if (!free_done)
                begin
                    state_next = ST_FREE_CHK;
                end
                else if (evict_mode_reg)
                begin
                    state_next = ST_TAKE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_FREE_CHK: state_next = ST_FREE_RD;
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (!sel_prot && sel_valid)
                begin
                    state_next = ST_FREE_RD;
                end
                else if (!sel_prot)
                begin
                    state_next = ST_TAKE;
                end
            end
            ST_TAKE:
            begin
                if (take_go)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        te_next         = cfg_wr_en ? cfg_wr_data : te_reg;
        v_next          = v_reg;
        pmask_next      = pmask_reg;
        rows_next       = rows_reg;
        inc_next        = inc_reg;
        div_rem_next    = div_rem_reg;
        div_q_next      = div_q_reg;
        div_cnt_next    = div_cnt_reg;
        htiles_next     = htiles_reg;
        vtiles_next     = vtiles_reg;
        need_next       = need_reg;
        own_valid_next  = own_valid_reg;
        own_id_next     = own_id_reg;
        cnt_next        = cnt_reg;
        resident_next   = resident_reg;
        ptr_next        = ptr_reg;
        visited_next    = visited_reg;
        taken_next      = taken_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        fv_next         = fv_reg;
        evict_mode_next = evict_mode_reg;
        k_next          = k_reg;
        ev_next         = ev_reg;
        evv_next        = evv_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        mem_we          = 1'b0;
        out_push        = 1'b0;
        empty_res       = '0;
        empty_res.last  = 1'b1;
        out_data        = empty_res;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    v_next       = VW'(vreg_id);
                    pmask_next   = protected_mask;
                    rows_next    = rows;
                    inc_next     = req_inc;
                    div_rem_next = '0;
                    div_q_next   = DIV_W'(cols) + DIV_W'(te_eff) - DIV_W'(1);
                    div_cnt_next = '0;
                    taken_next   = '0;
                    col_next     = '0;
                    row_next     = '0;
                    visited_next = '0;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_push            = 1'b1;
                    out_data.incomplete = inc_reg;
                end
            end
            ST_DIV_H:
            begin
                div_rem_next = div_rem_step;
                div_q_next   = div_q_step;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_done)
                begin
                    htiles_next  = div_q_step;
                    div_rem_next = '0;
                    div_q_next   = DIV_W'(rows_reg) + DIV_W'(te_eff) - DIV_W'(1);
                    div_cnt_next = '0;
                end
            end
            ST_DIV_V:
            begin
                div_rem_next = div_rem_step;
                div_q_next   = div_q_step;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_done)
                begin
                    vtiles_next = div_q_step;
                end
            end
            ST_NEED:
            begin
                need_next       = NEED_W'(htiles_reg) * NEED_W'(vtiles_reg);
                fv_next         = v_reg;
                k_next          = '0;
                evict_mode_next = 1'b0;
            end
            ST_FREE_RD:
            begin
                if (free_done && !evict_mode_reg)
                begin
                    cnt_next[v_reg] = '0;
                end
            end
            ST_FREE_CHK:
            begin
                if (sel_valid && (sel_id == fv_reg))
                begin
                    own_valid_next[pl_rd_reg] = 1'b0;
                end
                k_next = k_reg + CW'(1);
            end
            ST_WALK:
            begin
                if (!walk_done)
                begin
                    if (sel_prot)
                    begin
                        ptr_next     = ptr_inc;
                        visited_next = visited_reg + VCW'(1);
                    end
                    else if (sel_valid)
                    begin
                        ev_next                = 1'b1;
                        evv_next               = sel_id;
                        fv_next                = sel_id;
                        k_next                 = '0;
                        evict_mode_next        = 1'b1;
                        resident_next[sel_id]  = 1'b0;
                    end
                    else
                    begin
                        ev_next  = 1'b0;
                        evv_next = '0;
                    end
                end
            end
            ST_TAKE:
            begin
                if (take_go)
                begin
                    own_valid_next[ptr_reg] = 1'b1;
                    own_id_next[ptr_reg]    = v_reg;
                    mem_we                  = 1'b1;
                    cnt_next[v_reg]         = taken_reg + CW'(1);
                    if (pend_valid_reg)
                    begin
                        out_push = 1'b1;
                        out_data = pend_reg;
                    end
                    pend_valid_next          = 1'b1;
                    pend_next                = '0;
                    pend_next.assigned       = 1'b1;
                    pend_next.preg_index     = 4'(ptr_reg);
                    pend_next.tile_row       = 3'(row_reg);
                    pend_next.tile_col       = 3'(col_reg);
                    pend_next.evicted_valid  = ev_reg;
                    pend_next.evicted_vreg   = 4'(evv_reg);
                    taken_next               = taken_reg + CW'(1);
                    if ((DIV_W'(col_reg) + DIV_W'(1)) == htiles_reg)
                    begin
                        col_next = '0;
                        row_next = row_reg + CW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                    ptr_next     = ptr_inc;
                    visited_next = visited_reg + VCW'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    resident_next[v_reg] = 1'b1;
                    out_push             = 1'b1;
                    pend_valid_next      = 1'b0;
                    if (pend_valid_reg)
                    begin
                        out_data            = pend_reg;
                        out_data.last       = 1'b1;
                        out_data.incomplete = NEED_W'(taken_reg) < need_reg;
                    end
                    else
                    begin
                        out_data.incomplete = 1'b1;
                    end
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase

        out_valid_next = out_push || (out_valid_reg && out_stall);
        out_next       = out_push ? out_data : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            te_reg         <= TE_RESET;
            own_valid_reg  <= '0;
            cnt_reg        <= '{default: '0};
            resident_reg   <= '0;
            ptr_reg        <= '0;
            visited_reg    <= '0;
            taken_reg      <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            k_reg          <= '0;
            evict_mode_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            te_reg         <= te_next;
            own_valid_reg  <= own_valid_next;
            cnt_reg        <= cnt_next;
            resident_reg   <= resident_next;
            ptr_reg        <= ptr_next;
            visited_reg    <= visited_next;
            taken_reg      <= taken_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            k_reg          <= k_next;
            evict_mode_reg <= evict_mode_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        pmask_reg   <= pmask_next;
        rows_reg    <= rows_next;
        inc_reg     <= inc_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        div_cnt_reg <= div_cnt_next;
        htiles_reg  <= htiles_next;
        vtiles_reg  <= vtiles_next;
        need_reg    <= need_next;
        own_id_reg  <= own_id_next;
        fv_reg      <= fv_next;
        ev_reg      <= ev_next;
        evv_reg     <= evv_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    // placement list memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pl_mem[mem_waddr] <= ptr_reg;
        end
        pl_rd_reg <= pl_mem[mem_raddr];
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign assigned      = out_reg.assigned;
    assign preg_index    = out_reg.preg_index;
    assign tile_row      = out_reg.tile_row;
    assign tile_col      = out_reg.tile_col;
    assign evicted_valid = out_reg.evicted_valid;
    assign evicted_vreg  = out_reg.evicted_vreg;
    assign incomplete    = out_reg.incomplete;
    assign last          = out_reg.last;

    `RRTRA_ASSERT(a_ptr_range, clk, rst_n, ptr_reg <= SW'(NUM_SLOTS - 1))
    `RRTRA_ASSERT(a_take_slot_free, clk, rst_n, state_reg == ST_TAKE |-> !own_valid_reg[ptr_reg])
    `RRTRA_ASSERT(a_taken_cap, clk, rst_n, taken_reg <= CW'(MAX_PLACE))
    `RRTRA_ASSERT(a_resident_set, clk, rst_n, (state_reg == ST_FINISH && out_free) |=> resident_reg[v_reg])

endmodule

[test/tile_alloc_checker.sv]
`timescale 1ns / 1ps
module tile_alloc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [3:0]  vreg_id,
    input  logic [9:0]  rows,
    input  logic [9:0]  cols,
    input  logic        is_vector,
    input  logic        orientation,
    input  logic [15:0] protected_mask,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        assigned,
    input  logic [3:0]  preg_index,
    input  logic [2:0]  tile_row,
    input  logic [2:0]  tile_col,
    input  logic        evicted_valid,
    input  logic [3:0]  evicted_vreg,
    input  logic        incomplete,
    input  logic        last,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          evictions_seen
);
    import rrtra_pkg::*;

    localparam int SLOTS     = 16;
    localparam int VREGS     = 16;
    localparam int PLACE_MAX = 6;

    logic [7:0] tile_edge_q;
    logic       slot_busy [SLOTS];
    logic [3:0] slot_vreg [SLOTS];
    logic [3:0] rr_ptr;
    logic       list_ok   [VREGS][PLACE_MAX];
    logic [3:0] list_slot [VREGS][PLACE_MAX];
    logic       resident  [VREGS];
    result_t    placements_due [$];
    result_t    got;
    result_t    want;

    function automatic string show(input result_t b);
        return $sformatf("asg=%0d preg=%0d row=%0d col=%0d ev=%0d evreg=%0d inc=%0d last=%0d",
                         b.assigned, b.preg_index, b.tile_row, b.tile_col,
                         b.evicted_valid, b.evicted_vreg, b.incomplete, b.last);
    endfunction

    function automatic result_t empty_beat(input logic inc);
        result_t b;
        b = '0;
        b.incomplete = inc;
        b.last = 1'b1;
        return b;
    endfunction

    // free the listed slots that v still owns, up to the end mark
    task automatic release_slots(input logic [3:0] v);
        for (int k = 0; k < PLACE_MAX && list_ok[v][k]; k++)
        begin
            if (slot_busy[list_slot[v][k]] && slot_vreg[list_slot[v][k]] == v)
                slot_busy[list_slot[v][k]] = 1'b0;
        end
    endtask

    task automatic place_request(input logic [3:0] v, input logic [9:0] r, c,
                                 input logic vec, tr, input logic [15:0] mask);
        int unsigned te, htiles, vtiles, need, goal, taken;
        logic [3:0]  s;
        result_t     beats [PLACE_MAX];
        result_t     b;
        te = (tile_edge_q == 8'd0) ? 1 : 32'(tile_edge_q);
        htiles = (c + te - 1) / te;
        vtiles = (r + te - 1) / te;
        need = htiles * vtiles;
        if (vec && tr)
            placements_due.push_back(empty_beat(1'b0));
        else if (need == 0)
            placements_due.push_back(empty_beat(1'b0));
        else
        begin
            goal = (need > PLACE_MAX) ? PLACE_MAX : need;
            release_slots(v);
            for (int k = 0; k < PLACE_MAX; k++)
                list_ok[v][k] = 1'b0;
            taken = 0;
            for (int i = 0; i < SLOTS && taken < goal; i++)
            begin
                s = rr_ptr;
                if (!(slot_busy[s] && mask[slot_vreg[s]]))
                begin
                    b = '0;
                    if (slot_busy[s])
                    begin
                        b.evicted_valid = 1'b1;
                        b.evicted_vreg = slot_vreg[s];
                        release_slots(b.evicted_vreg);
                        resident[b.evicted_vreg] = 1'b0;
                    end
                    slot_busy[s] = 1'b1;
                    slot_vreg[s] = v;
                    list_ok[v][taken] = 1'b1;
                    list_slot[v][taken] = s;
                    b.assigned = 1'b1;
                    b.preg_index = s;
                    b.tile_row = 3'(taken / htiles);
                    b.tile_col = 3'(taken % htiles);
                    beats[taken] = b;
                    taken++;
                end
                rr_ptr = rr_ptr + 4'd1;
            end
            resident[v] = 1'b1;
            if (taken == 0)
                placements_due.push_back(empty_beat(1'b1));
            else
            begin
                beats[taken - 1].incomplete = (taken < need);
                beats[taken - 1].last = 1'b1;
                for (int k = 0; k < taken; k++)
                    placements_due.push_back(beats[k]);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_edge_q = TE_RESET;
            rr_ptr = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_busy[i] = 1'b0;
                slot_vreg[i] = '0;
            end
            for (int i = 0; i < VREGS; i++)
            begin
                resident[i] = 1'b0;
                for (int k = 0; k < PLACE_MAX; k++)
                begin
                    list_ok[i][k] = 1'b0;
                    list_slot[i][k] = '0;
                end
            end
            placements_due.delete();
        end
        else
        begin
            if (cfg_wr_en)
                tile_edge_q = cfg_wr_data;
            if (in_valid && !in_stall)
                place_request(vreg_id, rows, cols, is_vector, orientation, protected_mask);
            if (out_valid && !out_stall)
            begin
                got = {assigned, preg_index, tile_row, tile_col,
                       evicted_valid, evicted_vreg, incomplete, last};
                results_seen++;
                if (got.evicted_valid === 1'b1)
                    evictions_seen++;
                if (placements_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat with nothing expected: %s", $realtime, show(got));
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: result beat %0d mismatch", $realtime, results_seen);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(got));
                        end
                    end
                end
            end
        end
        pending = placements_due.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;

    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  vreg_id = '0;
    logic [9:0]  rows = '0;
    logic [9:0]  cols = '0;
    logic        is_vector = 1'b0;
    logic        orientation = 1'b0;
    logic [15:0] protected_mask = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        assigned;
    logic [3:0]  preg_index;
    logic [2:0]  tile_row;
    logic [2:0]  tile_col;
    logic        evicted_valid;
    logic [3:0]  evicted_vreg;
    logic        incomplete;
    logic        last;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          evictions_seen;
    int          requests_sent = 0;
    int unsigned cur_tile_edge = 24;
    logic [7:0]  edge_plan [6];
    bit          eager = 1'b0;
    bit          hold_results = 1'b0;
    int unsigned stall_left = 0;
    int unsigned span_left = 0;
    bit          busy = 1'b0;

    round_robin_tile_register_allocator_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .vreg_id        (vreg_id),
        .rows           (rows),
        .cols           (cols),
        .is_vector      (is_vector),
        .orientation    (orientation),
        .protected_mask (protected_mask),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .assigned       (assigned),
        .preg_index     (preg_index),
        .tile_row       (tile_row),
        .tile_col       (tile_col),
        .evicted_valid  (evicted_valid),
        .evicted_vreg   (evicted_vreg),
        .incomplete     (incomplete),
        .last           (last)
    );

    tile_alloc_checker placement_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .vreg_id        (vreg_id),
        .rows           (rows),
        .cols           (cols),
        .is_vector      (is_vector),
        .orientation    (orientation),
        .protected_mask (protected_mask),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .assigned       (assigned),
        .preg_index     (preg_index),
        .tile_row       (tile_row),
        .tile_col       (tile_col),
        .evicted_valid  (evicted_valid),
        .evicted_vreg   (evicted_vreg),
        .incomplete     (incomplete),
        .last           (last),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .evictions_seen (evictions_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("round_robin_tile_register_allocator_core test failed");
        $finish;
    end

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
    endfunction

    // result side: random stretches of stalls, plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_results)
        begin
            stall_left = HOLD_CYCLES;
            hold_results = 1'b0;
        end
        if (span_left == 0)
        begin
            span_left = $urandom_range(20, 150);
            busy = ($urandom_range(0, 2) != 0);
        end
        span_left--;
        if (stall_left == 0 && busy && $urandom_range(0, 4) == 0)
            stall_left = pick_gap();
        out_stall = (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    task automatic offer_request(input logic [3:0] v, input logic [9:0] r, c,
                                 input logic vec, tr, input logic [15:0] mask);
        int unsigned gap;
        @(negedge clk);
        vreg_id = v;
        rows = r;
        cols = c;
        is_vector = vec;
        orientation = tr;
        protected_mask = mask;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        gap = (eager || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    task automatic random_request();
        logic [3:0]  v;
        logic [9:0]  r, c;
        logic        vec, tr;
        logic [15:0] mask;
        int unsigned lim;
        lim = (cur_tile_edge == 0) ? 3 : cur_tile_edge * 3;
        if (lim > 1023)
            lim = 1023;
        v = 4'($urandom_range(0, 15));
        vec = ($urandom_range(0, 3) == 0);
        tr = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0)
        begin
            r = 10'($urandom);
            c = 10'($urandom);
        end
        else
        begin
            r = 10'($urandom_range(1, lim));
            c = vec ? 10'd1 : 10'($urandom_range(1, lim));
        end
        case ($urandom_range(0, 3))
            0: mask = '0;
            1: mask = 16'($urandom);
            2: mask = 16'($urandom & $urandom);
            default: mask = 16'hffff ^ (16'h1 << $urandom_range(0, 15));
        endcase
        offer_request(v, r, c, vec, tr, mask);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_tile_edge(input logic [7:0] val);
        settle();
        cfg_wr_en = 1'b1;
        cfg_wr_data = val;
        cur_tile_edge = 32'(val);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset tile edge of 24
        offer_request(4'd0, 10'd24, 10'd24, 1'b0, 1'b0, 16'h0000);
        offer_request(4'd1, 10'd1023, 10'd1023, 1'b0, 1'b0, 16'h0000);
        offer_request(4'd2, 10'd100, 10'd1, 1'b1, 1'b0, 16'h0000);
        offer_request(4'd3, 10'd100, 10'd1, 1'b1, 1'b1, 16'h0000);
        offer_request(4'd4, 10'd0, 10'd10, 1'b0, 1'b0, 16'h0000);
        offer_request(4'd4, 10'd10, 10'd0, 1'b0, 1'b0, 16'h0000);
        offer_request(4'd5, 10'd48, 10'd72, 1'b0, 1'b1, 16'h0000);
        offer_request(4'd1, 10'd24, 10'd24, 1'b0, 1'b0, 16'h0000);
        offer_request(4'd6, 10'd24, 10'd48, 1'b0, 1'b0, 16'hffff);
        // fill every slot with protected owners, then ask with all protected
        offer_request(4'd12, 10'd120, 10'd144, 1'b0, 1'b0, 16'h0000);
        offer_request(4'd13, 10'd120, 10'd144, 1'b0, 1'b0, 16'h1000);
        offer_request(4'd14, 10'd120, 10'd144, 1'b0, 1'b0, 16'h3000);
        offer_request(4'd10, 10'd24, 10'd24, 1'b0, 1'b0, 16'hffff);
        offer_request(4'd14, 10'd1023, 10'd24, 1'b0, 1'b0, 16'h3000);
        offer_request(4'd15, 10'd1, 10'd1, 1'b0, 1'b1, 16'h8000);
        offer_request(4'd15, 10'd24, 10'd1023, 1'b1, 1'b0, 16'h7fff);

        edge_plan = '{8'd1, 8'd255, 8'd0, 8'd7, 8'd24, 8'd24};
        edge_plan[4] = 8'($urandom_range(2, 254));
        for (int p = 0; p < 6; p++)
        begin
            set_tile_edge(edge_plan[p]);
            eager = (p % 2 == 1);
            if (p == 2)
            begin
                eager = 1'b1;
                hold_results = 1'b1;
                repeat (15) random_request();
                eager = 1'b0;
            end
            repeat (47) random_request();
        end

        settle();
        repeat (16) @(negedge clk);
        $display("covered %0d requests over seven tile edge settings, with a %0d-cycle output hold",
                 requests_sent, HOLD_CYCLES);
        $display("checked %0d result beats, %0d of them evicting a register",
                 results_seen, evictions_seen);
        if (fail_count == 0)
            $display("round_robin_tile_register_allocator_core test passed");
        else
            $display("round_robin_tile_register_allocator_core test failed");
        $finish;
    end

endmodule
